>>> rtl/aabs_pkg.sv
`timescale 1ns / 1ps
// aabs_pkg: shared types and codes for the ALU with barrel shifter.
// No dependencies; imported by every module of the block.
package aabs_pkg;

	// Data-processing opcodes
	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_RSC = 4'd7,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} opcode_t;

	// Shift kinds
	localparam logic [1:0] SK_LSL = 2'd0;
	localparam logic [1:0] SK_LSR = 2'd1;
	localparam logic [1:0] SK_ASR = 2'd2;
	localparam logic [1:0] SK_ROR = 2'd3;

	localparam logic [7:0] AMT_WORD = 8'd32;

	typedef struct packed {
		logic [31:0] value;
		logic        carry;
	} operand2_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} nzcv_t;

endpackage

>>> rtl/aabs_shifter.sv
`timescale 1ns / 1ps
// aabs_shifter: forms the second operand (rotated immediate or shifted register)
// and the shifter carry-out. Depends on aabs_pkg.
module aabs_shifter (
	input  logic                  immediate_form,
	input  logic [7:0]            imm_byte,
	input  logic [3:0]            imm_rotate,
	input  logic [1:0]            shift_kind,
	input  logic                  shift_by_reg,
	input  logic [4:0]            shift_imm,
	input  logic [7:0]            shift_reg_byte,
	input  logic [31:0]           rm,
	input  logic                  carry_in,
	output aabs_pkg::operand2_t   op2
);
	import aabs_pkg::*;

	logic [31:0] imm32;
	logic [63:0] imm_rot_wide;
	logic [7:0]  amt;
	logic [7:0]  eff_amt;
	logic        amt_zero;
	logic        amt_ge32;
	logic        amt_eq32;
	logic [32:0] lsl_wide;
	logic [32:0] lsr_wide;
	logic [32:0] asr_wide;
	logic [63:0] ror_wide;

	assign imm32        = {24'd0, imm_byte};
	assign imm_rot_wide = {imm32, imm32} >> {imm_rotate, 1'b0};

	assign amt      = shift_by_reg ? shift_reg_byte : {3'd0, shift_imm};
	assign amt_zero = (amt == 8'd0);
	// immediate LSR/ASR by zero means a shift by a full word
	assign eff_amt  = amt_zero ? AMT_WORD : amt;
	assign amt_ge32 = (eff_amt[7:5] != 3'd0);
	assign amt_eq32 = (eff_amt == AMT_WORD);

	assign lsl_wide = {1'b0, rm} << eff_amt[4:0];
	assign lsr_wide = {rm, 1'b0} >> eff_amt[4:0];
	assign asr_wide = 33'($signed({rm, 1'b0}) >>> eff_amt[4:0]);
	assign ror_wide = {rm, rm} >> eff_amt[4:0];

	always_comb begin
		op2.value = rm;
		op2.carry = carry_in;
		if (immediate_form) begin
			op2.value = imm_rot_wide[31:0];
			op2.carry = (imm_rotate == 4'd0) ? carry_in : imm_rot_wide[31];
		end else if (amt_zero && (shift_by_reg || shift_kind == SK_LSL)) begin
			op2.value = rm;
			op2.carry = carry_in;
		end else if (amt_zero && shift_kind == SK_ROR) begin
			// rotate right extended through the old carry
			op2.value = {carry_in, rm[31:1]};
			op2.carry = rm[0];
		end else begin
			unique case (shift_kind)
				SK_LSL: begin
					if (!amt_ge32) begin
						op2.value = lsl_wide[31:0];
						op2.carry = lsl_wide[32];
					end else begin
						op2.value = '0;
						op2.carry = amt_eq32 ? rm[0] : 1'b0;
					end
				end
				SK_LSR: begin
					if (!amt_ge32) begin
						op2.value = lsr_wide[32:1];
						op2.carry = lsr_wide[0];
					end else begin
						op2.value = '0;
						op2.carry = amt_eq32 ? rm[31] : 1'b0;
					end
				end
				SK_ASR: begin
					if (!amt_ge32) begin
						op2.value = asr_wide[32:1];
						op2.carry = asr_wide[0];
					end else begin
						op2.value = {32{rm[31]}};
						op2.carry = rm[31];
					end
				end
				SK_ROR: begin
					if (eff_amt[4:0] == 5'd0) begin
						op2.value = rm;
						op2.carry = rm[31];
					end else begin
						op2.value = ror_wide[31:0];
						op2.carry = ror_wide[31];
					end
				end
			endcase
		end
	end

endmodule

>>> rtl/aabs_alu.sv
`timescale 1ns / 1ps
// aabs_alu: the sixteen data-processing operations and the NZCV update.
// Depends on aabs_pkg.
module aabs_alu (
	input  aabs_pkg::opcode_t    opcode,
	input  logic                 set_flags,
	input  logic [31:0]          rn,
	input  aabs_pkg::operand2_t  op2,
	input  aabs_pkg::nzcv_t      flags_old,
	output logic [31:0]          alu_result,
	output logic                 writes_dest,
	output aabs_pkg::nzcv_t      flags_new
);
	import aabs_pkg::*;

	logic [31:0] add_a;
	logic [31:0] add_b;
	logic        add_ci;
	logic [32:0] sum;
	logic        add_v;
	logic        arith;

	// one shared 33-bit adder for all arithmetic opcodes
	assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_ci};
	assign add_v = (add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]);

	always_comb begin
		add_a      = rn;
		add_b      = op2.value;
		add_ci     = 1'b0;
		arith      = 1'b0;
		alu_result = '0;
		unique case (opcode)
			OP_AND, OP_TST: alu_result = rn & op2.value;
			OP_EOR, OP_TEQ: alu_result = rn ^ op2.value;
			OP_SUB, OP_CMP: begin
				add_b = ~op2.value; add_ci = 1'b1; arith = 1'b1; alu_result = sum[31:0];
			end
			OP_RSB: begin
				add_a = op2.value; add_b = ~rn; add_ci = 1'b1; arith = 1'b1;
				alu_result = sum[31:0];
			end
			OP_ADD, OP_CMN: begin
				arith = 1'b1; alu_result = sum[31:0];
			end
			OP_ADC: begin
				add_ci = flags_old.c; arith = 1'b1; alu_result = sum[31:0];
			end
			OP_SBC: begin
				add_b = ~op2.value; add_ci = flags_old.c; arith = 1'b1;
				alu_result = sum[31:0];
			end
			OP_RSC: begin
				add_a = op2.value; add_b = ~rn; add_ci = flags_old.c; arith = 1'b1;
				alu_result = sum[31:0];
			end
			OP_ORR: alu_result = rn | op2.value;
			OP_MOV: alu_result = op2.value;
			OP_BIC: alu_result = rn & ~op2.value;
			OP_MVN: alu_result = ~op2.value;
		endcase
	end

	assign writes_dest = !(opcode == OP_TST || opcode == OP_TEQ ||
		opcode == OP_CMP || opcode == OP_CMN);

	always_comb begin
		flags_new = flags_old;
		if (set_flags) begin
			flags_new.n = alu_result[31];
			flags_new.z = (alu_result == 32'd0);
			flags_new.c = arith ? sum[32] : op2.carry;
			flags_new.v = arith ? add_v : flags_old.v;
		end
	end

endmodule

>>> rtl/arm_alu_barrel_shifter.sv
`timescale 1ns / 1ps
// arm_alu_barrel_shifter: ARM data-processing execute stage with barrel shifter.
// Depends on aabs_pkg, aabs_shifter and aabs_alu.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one decoded data-processing
//   instruction with its register values; output channel (out_valid /
//   out_ready) returns the result word, the destination-write bit and NZCV.
//   Every input transfer produces exactly one output transfer, in order.
//   Path: an accepted instruction is captured in the input register, then
//   passes through shifter + ALU into the result register, from which it is
//   offered on the output.
//   Throughput: one instruction per cycle while the receiver does not stall;
//   the shifter and one 33-bit adder fit between the two registers.
//   The NZCV register advances when an instruction moves into the result
//   register, so the next instruction sees the flags left by this one.
//   Reset clears NZCV to zero and empties both stages.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more instruction, then in_ready drops until the stall
//   clears.
module arm_alu_barrel_shifter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic        set_flags,
	input  logic        immediate_form,
	input  logic [7:0]  imm_byte,
	input  logic [3:0]  imm_rotate,
	input  logic [1:0]  shift_kind,
	input  logic        shift_by_reg,
	input  logic [4:0]  shift_imm,
	input  logic [31:0] shift_reg_value,
	input  logic [31:0] first_operand,
	input  logic [31:0] shifted_operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] alu_result,
	output logic        writes_dest,
	output logic        flag_n,
	output logic        flag_z,
	output logic        flag_c,
	output logic        flag_v
);
	import aabs_pkg::*;

	// input register
	logic        valid_s1;
	opcode_t     opcode_s1;
	logic        set_flags_s1;
	logic        immediate_form_s1;
	logic [7:0]  imm_byte_s1;
	logic [3:0]  imm_rotate_s1;
	logic [1:0]  shift_kind_s1;
	logic        shift_by_reg_s1;
	logic [4:0]  shift_imm_s1;
	logic [7:0]  shift_reg_byte_s1;
	logic [31:0] first_operand_s1;
	logic [31:0] shifted_operand_s1;

	// architectural flags and result register
	nzcv_t       flags_q;
	logic        out_valid_q;
	logic [31:0] alu_result_q;
	logic        writes_dest_q;
	nzcv_t       out_flags_q;

	operand2_t   op2;
	logic [31:0] res;
	logic        wr_dest;
	nzcv_t       flags_next;
	logic        advance;

	// move s1 into the result register when it is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload: capture on every input transfer, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1          <= opcode_t'(opcode);
			set_flags_s1       <= set_flags;
			immediate_form_s1  <= immediate_form;
			imm_byte_s1        <= imm_byte;
			imm_rotate_s1      <= imm_rotate;
			shift_kind_s1      <= shift_kind;
			shift_by_reg_s1    <= shift_by_reg;
			shift_imm_s1       <= shift_imm;
			shift_reg_byte_s1  <= shift_reg_value[7:0];
			first_operand_s1   <= first_operand;
			shifted_operand_s1 <= shifted_operand;
		end
	end

	aabs_shifter u_shifter (
		.immediate_form (immediate_form_s1),
		.imm_byte       (imm_byte_s1),
		.imm_rotate     (imm_rotate_s1),
		.shift_kind     (shift_kind_s1),
		.shift_by_reg   (shift_by_reg_s1),
		.shift_imm      (shift_imm_s1),
		.shift_reg_byte (shift_reg_byte_s1),
		.rm             (shifted_operand_s1),
		.carry_in       (flags_q.c),
		.op2            (op2)
	);

	aabs_alu u_alu (
		.opcode      (opcode_s1),
		.set_flags   (set_flags_s1),
		.rn          (first_operand_s1),
		.op2         (op2),
		.flags_old   (flags_q),
		.alu_result  (res),
		.writes_dest (wr_dest),
		.flags_new   (flags_next)
	);

	// commit flags together with the result so the next instruction sees them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flags_q <= flags_next;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			alu_result_q  <= res;
			writes_dest_q <= wr_dest;
			out_flags_q   <= flags_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign alu_result  = alu_result_q;
	assign writes_dest = writes_dest_q;
	assign flag_n      = out_flags_q.n;
	assign flag_z      = out_flags_q.z;
	assign flag_c      = out_flags_q.c;
	assign flag_v      = out_flags_q.v;

	// a waiting result always shows the current architectural flags
	a_out_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_flags_q == flags_q))
		else $error("output flags differ from NZCV register");

	// flags hold unless a flag-setting instruction commits
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && set_flags_s1) |=> (flags_q == $past(flags_q)))
		else $error("NZCV changed without a flag-setting instruction");

	// an instruction in s1 never vanishes without moving on
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage dropped an instruction");

endmodule
